/* hdl/npd_pkg.sv */
// npd_pkg: shared types and constants for the nonpreemptive priority dispatcher.
// Depends on nothing.
package npd_pkg;
  localparam int MAX_JOBS_D   = 64;
  localparam int MAX_GROUPS_D = 16;
  localparam int TIME_BITS_D  = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam logic [6:0]  CNT_MAX = 7'd127;
  localparam logic [21:0] SUM_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {REQ_ADD = 2'd0, REQ_STEP = 2'd1, REQ_STATS = 2'd2,
                            REQ_NONE = 2'd3} req_t;
  typedef enum logic [2:0] {EV_IDLE = 3'd0, EV_EXEC = 3'd1, EV_MISS = 3'd2,
                            EV_DROP = 3'd3, EV_FIN = 3'd4, EV_FAIL = 3'd5,
                            EV_STATS = 3'd6, EV_ADDED = 3'd7} event_t;
  localparam logic [1:0] MODE_EDF = 2'd0, MODE_RM = 2'd1, MODE_PRIO = 2'd2;
  localparam logic [1:0] CFG_MODE = 2'd0, CFG_HORIZON = 2'd1, CFG_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        is_periodic;
    logic [7:0]  task_priority;
    logic [15:0] first_arrival;
    logic [15:0] exec_ticks;
    logic [15:0] rel_deadline;
    logic [15:0] period_ticks;
    logic [3:0]  query_group;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  group_id;
    logic [15:0] start_tick;
    logic [16:0] end_tick;
    logic [6:0]  miss_total;
    logic [21:0] resp_sum;
    logic [6:0]  job_total;
    logic [15:0] worst_resp;
  } out_item_t;
endpackage

/* hdl/npd_if.sv */
// npd_if: valid/ready channel carrying one payload of parameter type payload_t.
// Depends on nothing.
interface npd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/npd_ram.sv */
// npd_ram: generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module npd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/nonpreemptive_priority_dispatcher_top.sv */
// Channel  | dir | payload
// req      | in  | npd_pkg::in_item_t (request fields)
// res      | out | npd_pkg::out_item_t (one result per request, none for req_type 3)
// cfg      | in  | cfg_we / cfg_index / cfg_data, write only
// Add: writes the new job's instances into the table in turn, then the result; an add
// that is ignored or refused goes straight to the result. Step: table scan, one entry per
// cycle, then a shift-down pass that reads and writes back each entry moved.
// Stats: reads the group's totals. The job table is one RAM walked by a sequencer.
// Reset (rst, synchronous) empties the table via the fill count and clears group
// valid bits. Result register holds until taken; a new request waits meanwhile.
// Depends on npd_pkg, npd_if, npd_ram.
module nonpreemptive_priority_dispatcher_top
  import npd_pkg::*;
#(
  parameter int MAX_JOBS   = MAX_JOBS_D
) (
  input  logic                  clk,
  input  logic                  rst,
  npd_if.sink                   req,
  npd_if.source                 res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int MAX_GROUPS = MAX_GROUPS_D;
  localparam int JW = $clog2(MAX_JOBS);
  localparam int CW = JW + 1;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int EW = 16 + 17 + 16 + 16 + 4;

  typedef struct packed {
    logic [15:0] arr;
    logic [16:0] dl;
    logic [15:0] ex;
    logic [15:0] key;
    logic [3:0]  grp;
  } entry_t;

  typedef enum logic [3:0] {S_IDLE, S_ADD, S_SCAN, S_SCAN_LAST, S_DECIDE, S_SHIFT_RD,
                            S_SHIFT_WR, S_STAT, S_OUT} state_t;

  localparam out_item_t ADDED_R = '{event_kind: EV_ADDED, default: '0};

  state_t      state;
  logic [1:0]  sched_mode;
  logic [15:0] horizon;
  logic [6:0]  miss_limit;
  logic [16:0] now_tick;
  logic [6:0]  miss_count;
  logic [GW:0] next_group;
  logic [CW-1:0] fill;
  logic [MAX_GROUPS-1:0] gvalid;
  logic [21:0] grp_sum   [MAX_GROUPS];
  logic [6:0]  grp_cnt   [MAX_GROUPS];
  logic [15:0] grp_worst [MAX_GROUPS];

  in_item_t    item;
  out_item_t   out_r;
  logic        out_v;
  logic [16:0] a_cur;
  logic [15:0] key_r;
  logic [3:0]  g_r;
  logic [6:0]  cnt_r;
  logic [CW-1:0] idx;
  logic        best_v;
  logic [JW-1:0] best_i;
  entry_t      best_e;

  // job table RAM
  logic          we;
  logic [JW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  npd_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  assign req.ready = (state == S_IDLE) && !out_v;
  assign res.valid = out_v;
  assign res.data  = out_r;

  // scan compare of the entry just read against the best so far
  logic [JW-1:0] ridx;
  logic [16:0] k_new, k_best;
  logic        cand, better;
  assign ridx   = idx[JW-1:0] - JW'(1);
  assign k_new  = (sched_mode == MODE_RM || sched_mode == MODE_PRIO) ? {1'b0, rdata.key} : rdata.dl;
  assign k_best = (sched_mode == MODE_RM || sched_mode == MODE_PRIO) ? {1'b0, best_e.key} : best_e.dl;
  assign cand   = ({1'b0, rdata.arr} <= now_tick);
  assign better = !best_v || (k_new < k_best) ||
                  (k_new == k_best && rdata.arr < best_e.arr);

  logic [16:0] fin;
  logic [16:0] resp;
  logic [22:0] sum_w;
  logic [GW-1:0] bg;
  assign fin   = now_tick + {1'b0, best_e.ex};
  assign resp  = now_tick - {1'b0, best_e.arr};
  assign bg    = GW'(best_e.grp);
  assign sum_w = {1'b0, grp_sum[bg]} + {6'd0, resp};

  logic [16:0] a_nxt;
  logic [15:0] per_eff;
  assign per_eff = (item.period_ticks == '0) ? 16'd1 : item.period_ticks;
  assign a_nxt   = a_cur + {1'b0, per_eff};

  always_comb begin
    we = 1'b0;
    waddr = fill[JW-1:0];
    wdata.arr = a_cur[15:0];
    wdata.dl  = a_cur + {1'b0, item.rel_deadline};
    wdata.ex  = item.exec_ticks;
    wdata.key = key_r;
    wdata.grp = g_r;
    raddr = idx[JW-1:0];
    if (state == S_ADD && fill < CW'(MAX_JOBS)) we = 1'b1;
    if (state == S_SHIFT_WR) begin
      we = 1'b1;
      waddr = idx[JW-1:0] - JW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; sched_mode <= MODE_EDF; horizon <= 16'd1000; miss_limit <= 7'd5;
      now_tick <= '0; miss_count <= '0; next_group <= '0; fill <= '0; gvalid <= '0;
      out_v <= 1'b0; best_v <= 1'b0; idx <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:    sched_mode <= cfg_data[1:0];
          CFG_HORIZON: horizon <= cfg_data;
          CFG_MISS:    miss_limit <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          item <= req.data;
          a_cur <= {1'b0, req.data.first_arrival};
          cnt_r <= '0; idx <= '0; best_v <= 1'b0;
          g_r <= next_group[3:0];
          key_r <= (sched_mode == MODE_RM) ? ((req.data.period_ticks == '0) ? 16'd1
                   : req.data.period_ticks) : (sched_mode == MODE_PRIO)
                   ? {8'd0, req.data.task_priority} : 16'd0;
          unique case (req_t'(req.data.req_type))
            REQ_ADD: begin
              if ((sched_mode == MODE_RM && !req.data.is_periodic) ||
                  next_group >= (GW+1)'(MAX_GROUPS)) begin
                out_r <= ADDED_R;
                state <= S_OUT;
              end else begin
                out_r <= '0;
                next_group <= next_group + 1'b1;
                state <= S_ADD;
              end
            end
            REQ_STEP: begin
              out_r <= '0;
              state <= (fill == '0) ? S_SCAN_LAST : S_SCAN;
            end
            REQ_STATS: begin
              out_r <= '0;
              state <= S_STAT;
            end
            default: ;
          endcase
        end
        S_ADD: begin
          // one job per cycle
          logic stop;
          stop = 1'b0;
          if (fill >= CW'(MAX_JOBS)) stop = 1'b1;
          else begin
            fill <= fill + 1'b1;
            cnt_r <= (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
            if (!item.is_periodic) stop = 1'b1;
            else if (a_nxt < {1'b0, horizon}) begin
              a_cur <= a_nxt;
              if (a_nxt + {1'b0, item.exec_ticks} > {1'b0, horizon}) stop = 1'b1;
            end else stop = 1'b1;
          end
          if (stop) begin
            logic [6:0] c;
            c = (fill >= CW'(MAX_JOBS)) ? cnt_r : ((cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1);
            grp_cnt[GW'(g_r)] <= c;
            grp_sum[GW'(g_r)] <= '0;
            grp_worst[GW'(g_r)] <= '0;
            gvalid[GW'(g_r)] <= 1'b1;
            out_r.event_kind <= EV_ADDED;
            out_r.group_id <= g_r;
            out_r.start_tick <= item.first_arrival;
            out_r.job_total <= c;
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          // read issued at idx; data for idx-1 arrives
          if (idx != '0 && cand && better) begin
            best_v <= 1'b1; best_i <= ridx; best_e <= rdata;
          end
          idx <= idx + 1'b1;
          if (idx + 1'b1 == fill) state <= S_SCAN_LAST;
        end
        S_SCAN_LAST: begin
          if (idx != '0 && cand && better) begin
            best_v <= 1'b1; best_i <= ridx; best_e <= rdata;
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          out_r.start_tick <= now_tick[15:0];
          if (now_tick > {1'b0, horizon}) begin
            out_r.event_kind <= (miss_count > miss_limit) ? EV_FAIL : EV_FIN;
            out_r.end_tick <= now_tick;
            state <= S_OUT;
          end else if (!best_v) begin
            out_r.event_kind <= EV_IDLE;
            out_r.end_tick <= now_tick + 17'd1;
            now_tick <= now_tick + 17'd1;
            state <= S_OUT;
          end else begin
            out_r.group_id <= best_e.grp;
            out_r.end_tick <= fin;
            if (fin < {1'b0, horizon}) begin
              if (best_e.dl > fin) begin
                if (gvalid[bg]) begin
                  grp_sum[bg] <= sum_w[22] ? SUM_MAX : sum_w[21:0];
                  if (resp[15:0] > grp_worst[bg]) grp_worst[bg] <= resp[15:0];
                end
                now_tick <= fin;
                out_r.event_kind <= EV_EXEC;
              end else begin
                if (miss_count < CNT_MAX) miss_count <= miss_count + 1'b1;
                out_r.event_kind <= EV_MISS;
              end
            end else out_r.event_kind <= EV_DROP;
            idx <= {1'b0, best_i} + 1'b1;
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (idx >= fill) begin
            fill <= fill - 1'b1;
            state <= S_OUT;
          end else state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx <= idx + 1'b1;
          state <= S_SHIFT_RD;
        end
        S_STAT: begin
          out_r.event_kind <= EV_STATS;
          out_r.group_id <= item.query_group;
          if ({1'b0, item.query_group} < 5'(MAX_GROUPS) && gvalid[GW'(item.query_group)]) begin
            out_r.resp_sum <= grp_sum[GW'(item.query_group)];
            out_r.job_total <= grp_cnt[GW'(item.query_group)];
            out_r.worst_resp <= grp_worst[GW'(item.query_group)];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_r.miss_total <= miss_count;
          out_v <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= CW'(MAX_JOBS))
    else $error("fill count beyond table");
  a_busy: assert property (@(posedge clk) disable iff (rst) out_v |-> !req.ready)
    else $error("ready while result pending");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_v) else $error("result not raised");
`endif
endmodule
